[rtl/string_interleave_checker_macros.svh]
// Assertion macros used by the string interleave checker top level.
`ifndef STRING_INTERLEAVE_CHECKER_MACROS_SVH
`define STRING_INTERLEAVE_CHECKER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SIC_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SIC_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/sic_pkg.sv]
// Package with sizes, opcodes and shared types of the string interleave checker.
`default_nettype none

package sic_pkg;

  // Longest first or second string that the block holds.
  localparam int unsigned MAX_LEN = 64;

  // Width of a string length (0 .. MAX_LEN).
  localparam int unsigned LEN_W = $clog2(MAX_LEN + 1);
  // Width of an index into a string store (0 .. MAX_LEN-1).
  localparam int unsigned IDX_W = ($clog2(MAX_LEN) > 0) ? $clog2(MAX_LEN) : 1;
  // The target count saturates here, so an overlong target never matches.
  localparam int unsigned TGT_SAT = 2 * MAX_LEN + 1;
  localparam int unsigned TGT_W = $clog2(TGT_SAT + 1);

  typedef enum logic [1:0] {
    OP_FIRST  = 2'd0,
    OP_SECOND = 2'd1,
    OP_TARGET = 2'd2,
    OP_END    = 2'd3
  } op_e;

  typedef logic [7:0] char_t;

  // Controls from the sequencing logic to the reachability lattice.
  typedef struct packed {
    logic             load_first;
    logic             load_second;
    logic             step;
    logic             clear_bits;
    logic             restart;
    char_t            ch;
    logic [LEN_W-1:0] first_len;
    logic [LEN_W-1:0] second_len;
    logic [TGT_W-1:0] tgt_cnt;
  } reach_ctl_t;

endpackage

`default_nettype wire

[rtl/sic_in_if.sv]
// Input channel interface of the string interleave checker.
`default_nettype none

interface sic_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] opcode;
  logic [7:0] char_value;

  modport source (output valid, output opcode, output char_value, input ready);
  modport sink (input valid, input opcode, input char_value, output ready);
endinterface

`default_nettype wire

[rtl/sic_out_if.sv]
// Result channel interface of the string interleave checker.
`default_nettype none

interface sic_out_if;
  logic valid;
  logic ready;
  logic verdict;
  logic error_flag;

  modport source (output valid, output verdict, output error_flag, input ready);
  modport sink (input valid, input verdict, input error_flag, output ready);
endinterface

`default_nettype wire

[rtl/sic_reach.sv]
// String stores and the reachable split-point lattice of the checker.
`default_nettype none

module sic_reach (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire sic_pkg::reach_ctl_t ctl_i,
  output logic                     end_hit_o
);

  localparam int unsigned N = sic_pkg::MAX_LEN;

  // First string, read by each lane above lane zero at a fixed entry.
  sic_pkg::char_t first_mem_q [N];
  // Second string characters not yet lined up with lane zero.
  sic_pkg::char_t second_queue_q [N];
  // window_q[k] holds second[t-1-k], so lane k+1 always reads its own entry.
  sic_pkg::char_t window_q [N];

  logic [N:0] reach_q;
  logic [N:0] reach_step;

  always_ff @(posedge clk_i) begin
    if (ctl_i.load_first) begin
      first_mem_q[ctl_i.first_len[sic_pkg::IDX_W-1:0]] <= ctl_i.ch;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.load_second) begin
      second_queue_q[ctl_i.second_len[sic_pkg::IDX_W-1:0]] <= ctl_i.ch;
    end else if (ctl_i.step) begin
      for (int k = 0; k < N - 1; k++) begin
        second_queue_q[k] <= second_queue_q[k+1];
      end
      window_q[0] <= second_queue_q[0];
      for (int k = 1; k < N; k++) begin
        window_q[k] <= window_q[k-1];
      end
    end
  end

  // Bit i means i first-string characters and t-i second-string characters
  // can account for the target so far.
  for (genvar i = 0; i <= N; i++) begin : g_lane
    logic                     via_first;
    logic                     via_second;
    logic [sic_pkg::TGT_W-1:0] sec_idx;
    sic_pkg::char_t           sec_char;

    if (i == 0) begin : g_lo
      assign via_first = 1'b0;
      assign sec_char  = second_queue_q[0];
    end else begin : g_hi
      assign via_first = (sic_pkg::LEN_W'(i - 1) < ctl_i.first_len)
                      && (sic_pkg::TGT_W'(i - 1) <= ctl_i.tgt_cnt)
                      && reach_q[i-1]
                      && (first_mem_q[i-1] == ctl_i.ch);
      assign sec_char  = window_q[i-1];
    end

    assign sec_idx    = ctl_i.tgt_cnt - sic_pkg::TGT_W'(i);
    assign via_second = (sic_pkg::TGT_W'(i) <= ctl_i.tgt_cnt)
                     && (sec_idx < sic_pkg::TGT_W'(ctl_i.second_len))
                     && reach_q[i]
                     && (sec_char == ctl_i.ch);
    assign reach_step[i] = via_first || via_second;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reach_q <= (N+1)'(1);
    end else if (ctl_i.restart) begin
      reach_q <= (N+1)'(1);
    end else if (ctl_i.clear_bits) begin
      reach_q <= '0;
    end else if (ctl_i.step) begin
      reach_q <= reach_step;
    end
  end

  assign end_hit_o = reach_q[ctl_i.first_len];

endmodule

`default_nettype wire

[rtl/string_interleave_checker.sv]
// Top level of the string interleave checker.
//
//   channel | dir | payload                 | handshake
//   --------+-----+-------------------------+------------------------------
//   in_i    | in  | opcode[1:0], char_value | valid/ready, taken when both
//   out_o   | out | verdict, error_flag     | valid/ready, one item per end
//
// Flow: an item is taken into an input register and then processed, so one
// item per cycle is sustained while no end item waits on a held result; the
// whole lattice of split points updates at once. An end item passes the input
// register, then the result register. Reset clears lengths, counts and flags
// and restarts the lattice; the string stores are not cleared. A held result
// stalls only end items: loads and target characters keep flowing past it.
`default_nettype none

module string_interleave_checker (
  input wire logic clk_i,
  input wire logic rst_ni,
  sic_in_if.sink   in_i,
  sic_out_if.source out_o
);

  `include "string_interleave_checker_macros.svh"

  localparam int unsigned LEN_W = sic_pkg::LEN_W;
  localparam int unsigned TGT_W = sic_pkg::TGT_W;

  // Input register.
  logic           in_vld_q, in_vld_d;
  sic_pkg::op_e   op_q;
  sic_pkg::char_t ch_q;

  // Result register.
  logic out_vld_q, out_vld_d;
  logic verdict_q, verdict_d;
  logic error_q, error_d;

  // Sequencing state.
  logic [LEN_W-1:0] first_len_q, first_len_d;
  logic [LEN_W-1:0] second_len_q, second_len_d;
  logic [TGT_W-1:0] tgt_cnt_q, tgt_cnt_d;
  logic             started_q, started_d;
  logic             fault_q, fault_d;

  logic                adv;
  logic                in_take;
  logic [TGT_W-1:0]    total;
  logic                in_range;
  logic                first_ok;
  logic                second_ok;
  logic                end_hit;
  sic_pkg::reach_ctl_t ctl;

  // The item in the input register moves on unless it is an end item and the
  // result register is still occupied.
  assign adv = in_vld_q
            && ((op_q != sic_pkg::OP_END) || !out_vld_q || out_o.ready);
  assign in_i.ready = !in_vld_q || adv;
  assign in_take    = in_i.valid && in_i.ready;

  assign total     = TGT_W'(first_len_q) + TGT_W'(second_len_q);
  assign in_range  = tgt_cnt_q < total;
  assign first_ok  = !started_q && (first_len_q < LEN_W'(sic_pkg::MAX_LEN));
  assign second_ok = !started_q && (second_len_q < LEN_W'(sic_pkg::MAX_LEN));

  always_comb begin
    ctl             = '0;
    ctl.ch          = ch_q;
    ctl.first_len   = first_len_q;
    ctl.second_len  = second_len_q;
    ctl.tgt_cnt     = tgt_cnt_q;
    ctl.load_first  = adv && (op_q == sic_pkg::OP_FIRST) && first_ok;
    ctl.load_second = adv && (op_q == sic_pkg::OP_SECOND) && second_ok;
    ctl.step        = adv && (op_q == sic_pkg::OP_TARGET) && in_range;
    ctl.clear_bits  = adv && (op_q == sic_pkg::OP_TARGET) && !in_range;
    ctl.restart     = adv && (op_q == sic_pkg::OP_END);
  end

  sic_reach u_reach (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctl_i    (ctl),
    .end_hit_o(end_hit)
  );

  always_comb begin
    in_vld_d     = in_vld_q;
    out_vld_d    = out_vld_q;
    verdict_d    = verdict_q;
    error_d      = error_q;
    first_len_d  = first_len_q;
    second_len_d = second_len_q;
    tgt_cnt_d    = tgt_cnt_q;
    started_d    = started_q;
    fault_d      = fault_q;

    if (in_take) begin
      in_vld_d = 1'b1;
    end else if (adv) begin
      in_vld_d = 1'b0;
    end

    if (out_vld_q && out_o.ready) begin
      out_vld_d = 1'b0;
    end

    if (adv) begin
      case (op_q)
        sic_pkg::OP_FIRST: begin
          if (first_ok) begin
            first_len_d = first_len_q + LEN_W'(1);
          end else begin
            fault_d = 1'b1;
          end
        end
        sic_pkg::OP_SECOND: begin
          if (second_ok) begin
            second_len_d = second_len_q + LEN_W'(1);
          end else begin
            fault_d = 1'b1;
          end
        end
        sic_pkg::OP_TARGET: begin
          started_d = 1'b1;
          // The count saturates at TGT_SAT, above any combined length, so the length
          // test at the end item fails.
          if (tgt_cnt_q < TGT_W'(sic_pkg::TGT_SAT)) begin
            tgt_cnt_d = tgt_cnt_q + TGT_W'(1);
          end
        end
        sic_pkg::OP_END: begin
          out_vld_d    = 1'b1;
          verdict_d    = !fault_q && (total == tgt_cnt_q) && end_hit;
          error_d      = fault_q;
          first_len_d  = '0;
          second_len_d = '0;
          tgt_cnt_d    = '0;
          started_d    = 1'b0;
          fault_d      = 1'b0;
        end
        default: begin
          fault_d = fault_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q     <= 1'b0;
      out_vld_q    <= 1'b0;
      first_len_q  <= '0;
      second_len_q <= '0;
      tgt_cnt_q    <= '0;
      started_q    <= 1'b0;
      fault_q      <= 1'b0;
    end else begin
      in_vld_q     <= in_vld_d;
      out_vld_q    <= out_vld_d;
      first_len_q  <= first_len_d;
      second_len_q <= second_len_d;
      tgt_cnt_q    <= tgt_cnt_d;
      started_q    <= started_d;
      fault_q      <= fault_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      op_q <= sic_pkg::op_e'(in_i.opcode);
      ch_q <= in_i.char_value;
    end
    verdict_q <= verdict_d;
    error_q   <= error_d;
  end

  assign out_o.valid      = out_vld_q;
  assign out_o.verdict    = verdict_q;
  assign out_o.error_flag = error_q;

  // A fault always forces a false verdict.
  `SIC_ASSERT_NOW(a_fault_false, clk_i, rst_ni, out_vld_q && error_q, !verdict_q, "fault with true verdict")
  // A processed end item leaves the sequencing state cleared.
  `SIC_ASSERT_NEXT(a_end_clears, clk_i, rst_ni, ctl.restart, (first_len_q == '0) && (second_len_q == '0) && (tgt_cnt_q == '0) && !fault_q && !started_q, "end item did not clear state")
  // A new result only appears after an end item was processed.
  `SIC_ASSERT_NOW(a_result_src, clk_i, rst_ni, $rose(out_vld_q), $past(ctl.restart), "result without end item")
  // Lengths and the target count stay in range.
  `SIC_ASSERT_NOW(a_len_range, clk_i, rst_ni, 1'b1, (first_len_q <= LEN_W'(sic_pkg::MAX_LEN)) && (second_len_q <= LEN_W'(sic_pkg::MAX_LEN)) && (tgt_cnt_q <= TGT_W'(sic_pkg::TGT_SAT)), "length or count out of range")
  // Loads are never taken once the target has started.
  `SIC_ASSERT_NOW(a_no_late_load, clk_i, rst_ni, started_q, !ctl.load_first && !ctl.load_second, "load after target start")

endmodule

`default_nettype wire
